// ===== src/mlzn_pkg.sv =====
// Shared types and constants for the masked local z-score normalizer.
package mlzn_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int COUNT_W  = 13;
    localparam int SUM_W    = 28;
    localparam int SQSUM_W  = 43;
    localparam int RESULT_W = 16;
    localparam int SQ_LO_W  = 22;
    localparam int SQ_HI_W  = SQSUM_W - SQ_LO_W;
    localparam int DEN_W    = COUNT_W + SQSUM_W;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FLAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    neg;
    } ctl_t;

endpackage

// ===== src/mlzn_front.sv =====
// Front pipeline: products, variance term D, numerator magnitude and its square.
module mlzn_front #(
    parameter int PIXEL_BITS = mlzn_pkg::PIXEL_BITS_DEF,
    parameter int NUM_W      = 30
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [mlzn_pkg::COUNT_W-1:0]        mask_count,
    input  logic signed [mlzn_pkg::SUM_W-1:0]   masked_sum,
    input  logic [mlzn_pkg::SQSUM_W-1:0]        masked_square_sum,
    input  logic signed [PIXEL_BITS-1:0]        centre_pixel,
    output mlzn_pkg::ctl_t                      ctl_o,
    output logic [mlzn_pkg::DEN_W-1:0]          den_o,
    output logic [2*NUM_W-1:0]                  asq_o
);
    localparam int CW   = mlzn_pkg::COUNT_W;
    localparam int NX_W = CW + PIXEL_BITS + 1;
    localparam int DW   = mlzn_pkg::DEN_W;

    // stage 1
    logic                                   v1_reg;
    logic                                   nzero1_reg;
    logic [CW+mlzn_pkg::SQ_LO_W-1:0]        plo1_reg;
    logic [CW+mlzn_pkg::SQ_HI_W-1:0]        phi1_reg;
    logic [DW-1:0]                          ss1_reg;
    logic signed [NX_W-1:0]                 nx1_reg;
    logic signed [mlzn_pkg::SUM_W-1:0]      s1_reg;
    // stage 2
    mlzn_pkg::ctl_t                         ctl2_reg;
    logic [DW-1:0]                          d2_reg;
    logic [NUM_W-1:0]                       a2_reg;
    // stage 3
    mlzn_pkg::ctl_t                         ctl3_reg;
    logic [DW-1:0]                          d3_reg;
    logic [2*NUM_W-1:0]                     asq3_reg;

    logic [DW-1:0]                          dq;
    logic signed [DW+1:0]                   dsig;
    logic signed [NUM_W-1:0]                num;
    logic signed [2*mlzn_pkg::SUM_W-1:0]    sum_sq;
    mlzn_pkg::ctl_t                         ctl2_next;

    always_comb begin
        sum_sq = masked_sum * masked_sum;
        dq = DW'({phi1_reg, {mlzn_pkg::SQ_LO_W{1'b0}}}) + DW'(plo1_reg);
        dsig = $signed({2'b00, dq}) - $signed({2'b00, ss1_reg});
        num = NUM_W'(nx1_reg) - NUM_W'(s1_reg);
        ctl2_next.valid = v1_reg;
        ctl2_next.neg = num[NUM_W-1];
        if (nzero1_reg) begin
            ctl2_next.status = mlzn_pkg::ST_EMPTY;
        end else if (dsig <= 0) begin
            ctl2_next.status = mlzn_pkg::ST_FLAT;
        end else begin
            ctl2_next.status = mlzn_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else if (en) begin
            v1_reg <= in_valid;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nzero1_reg <= (mask_count == '0);
            plo1_reg <= mask_count * masked_square_sum[mlzn_pkg::SQ_LO_W-1:0];
            phi1_reg <= mask_count * masked_square_sum[mlzn_pkg::SQSUM_W-1:mlzn_pkg::SQ_LO_W];
            ss1_reg <= DW'($unsigned(sum_sq));
            nx1_reg <= $signed({1'b0, mask_count}) * centre_pixel;
            s1_reg <= masked_sum;
            d2_reg <= dsig[DW-1:0];
            a2_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            d3_reg <= d2_reg;
            asq3_reg <= a2_reg * a2_reg;
        end
    end

    assign ctl_o = ctl3_reg;
    assign den_o = d3_reg;
    assign asq_o = asq3_reg;

endmodule

// ===== src/mlzn_cell.sv =====
// One cell of the result chain: decides one bit of the rounded score magnitude.
module mlzn_cell #(
    parameter int J  = 0,
    parameter int CW = 96
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  mlzn_pkg::ctl_t                      ctl_i,
    input  logic signed [CW-1:0]                p_i,
    input  logic signed [CW-1:0]                l_i,
    input  logic [mlzn_pkg::DEN_W-1:0]          d_i,
    input  logic signed [CW-1:0]                b_i,
    input  logic [mlzn_pkg::RESULT_W-1:0]       r_i,
    output mlzn_pkg::ctl_t                      ctl_o,
    output logic signed [CW-1:0]                p_o,
    output logic signed [CW-1:0]                l_o,
    output logic [mlzn_pkg::DEN_W-1:0]          d_o,
    output logic signed [CW-1:0]                b_o,
    output logic [mlzn_pkg::RESULT_W-1:0]       r_o
);
    localparam int RW = mlzn_pkg::RESULT_W;

    mlzn_pkg::ctl_t         ctl_reg;
    logic signed [CW-1:0]   p_reg, l_reg, b_reg;
    logic [mlzn_pkg::DEN_W-1:0] d_reg;
    logic [RW-1:0]          r_reg;

    logic signed [CW-1:0]   dx;
    logic signed [CW-1:0]   p_cand;
    logic [RW-1:0]          cand;
    logic [RW-1:0]          cap;
    logic                   take;

    // P tracks (2r-1)^2*D and L tracks (2r-1)*D for the bits settled so far.
    always_comb begin
        dx = $signed({{(CW-mlzn_pkg::DEN_W){1'b0}}, d_i});
        p_cand = p_i + (l_i <<< (J + 2)) + (dx <<< (2 * J + 2));
        cand = r_i | (RW'(1) << J);
        cap = ctl_i.neg ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
        take = (ctl_i.status == mlzn_pkg::ST_OK) && (cand <= cap) && (p_cand <= b_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= take ? p_cand : p_i;
            l_reg <= take ? l_i + (dx <<< (J + 1)) : l_i;
            r_reg <= take ? cand : r_i;
            d_reg <= d_i;
            b_reg <= b_i;
        end
    end

    assign ctl_o = ctl_reg;
    assign p_o = p_reg;
    assign l_o = l_reg;
    assign d_o = d_reg;
    assign b_o = b_reg;
    assign r_o = r_reg;

endmodule

// ===== src/masked_local_zscore_normalize.sv =====
// Masked local z-score normalizer: top level with front pipeline and bit chain.
//
// Input words carry a window's mask count n, masked sum S, masked square sum Q
// and the centre pixel x on a valid/ready channel; one result word with the
// Q.FRAC_BITS z-score (n*x - S)/sqrt(n*Q - S*S), rounded half away from zero
// and saturated to 16 bits, plus a status code, leaves on the m_ channel.
// Status 1 marks an empty mask and status 2 a non-positive variance; the
// value is then zero.
// The pipeline has three front stages (products, variance and numerator,
// numerator square) and one cell per result bit, 16 cells, whose last
// registers hold the outgoing word. A new word is taken every cycle unless the receiver stalls.
// The whole pipeline advances together: when the receiver stalls with a
// word waiting, s_ready drops and every stage holds.
// Reset clears all valid flags; nothing is in flight afterwards.
module masked_local_zscore_normalize #(
    parameter int PIXEL_BITS = mlzn_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = mlzn_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mlzn_pkg::COUNT_W-1:0]        s_mask_count,
    input  logic signed [mlzn_pkg::SUM_W-1:0]   s_masked_sum,
    input  logic [mlzn_pkg::SQSUM_W-1:0]        s_masked_square_sum,
    input  logic signed [PIXEL_BITS-1:0]        s_centre_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mlzn_pkg::RESULT_W-1:0] m_normalized_value,
    output logic [1:0]                          m_status
);
    localparam int RW    = mlzn_pkg::RESULT_W;
    localparam int NX_W  = mlzn_pkg::COUNT_W + PIXEL_BITS + 1;
    localparam int NUM_W = (NX_W > mlzn_pkg::SUM_W ? NX_W : mlzn_pkg::SUM_W) + 1;
    localparam int B_W   = 2 * NUM_W + 2 * FRAC_BITS + 2;
    localparam int P_W   = 2 * (RW + 1) + mlzn_pkg::DEN_W + 2;
    localparam int CW    = (B_W > P_W ? B_W : P_W) + 2;
    localparam int DW    = mlzn_pkg::DEN_W;

    logic en;
    mlzn_pkg::ctl_t  fctl;
    logic [DW-1:0]   fden;
    logic [2*NUM_W-1:0] fasq;

    mlzn_pkg::ctl_t        ctl_c [RW+1];
    logic signed [CW-1:0]  p_c   [RW+1];
    logic signed [CW-1:0]  l_c   [RW+1];
    logic [DW-1:0]         d_c   [RW+1];
    logic signed [CW-1:0]  b_c   [RW+1];
    logic [RW-1:0]         r_c   [RW+1];

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    mlzn_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .NUM_W      (NUM_W)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_valid),
        .mask_count        (s_mask_count),
        .masked_sum        (s_masked_sum),
        .masked_square_sum (s_masked_square_sum),
        .centre_pixel      (s_centre_pixel),
        .ctl_o             (fctl),
        .den_o             (fden),
        .asq_o             (fasq)
    );

    // Before any bit is set r is zero, so P starts at D and L at -D.
    always_comb begin
        ctl_c[0] = fctl;
        d_c[0] = fden;
        p_c[0] = $signed({{(CW-DW){1'b0}}, fden});
        l_c[0] = -$signed({{(CW-DW){1'b0}}, fden});
        b_c[0] = $signed({{(CW-B_W){1'b0}}, fasq, {(2*FRAC_BITS+2){1'b0}}});
        r_c[0] = '0;
    end

    for (genvar i = 0; i < RW; i++) begin : g_cell
        mlzn_cell #(
            .J  (RW - 1 - i),
            .CW (CW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (ctl_c[i]),
            .p_i     (p_c[i]),
            .l_i     (l_c[i]),
            .d_i     (d_c[i]),
            .b_i     (b_c[i]),
            .r_i     (r_c[i]),
            .ctl_o   (ctl_c[i+1]),
            .p_o     (p_c[i+1]),
            .l_o     (l_c[i+1]),
            .d_o     (d_c[i+1]),
            .b_o     (b_c[i+1]),
            .r_o     (r_c[i+1])
        );
    end

    always_comb begin
        m_valid = ctl_c[RW].valid;
        m_status = ctl_c[RW].status;
        if (ctl_c[RW].status != mlzn_pkg::ST_OK) begin
            m_normalized_value = '0;
        end else if (ctl_c[RW].neg) begin
            m_normalized_value = -$signed(r_c[RW]);
        end else begin
            m_normalized_value = $signed(r_c[RW]);
        end
    end

endmodule

// ===== src/mlzn_checker.sv =====
// Port-level checker for the masked local z-score normalizer, with its bind.
module mlzn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_normalized_value,
    input logic [1:0]  m_status
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normalized_value) && $stable(m_status))
        else $error("result word changed while stalled");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == mlzn_pkg::ST_EMPTY || m_status == mlzn_pkg::ST_FLAT)
        |-> m_normalized_value == 16'd0)
        else $error("flagged word carries a nonzero value");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output space");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind masked_local_zscore_normalize mlzn_checker u_mlzn_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_normalized_value (m_normalized_value),
    .m_status           (m_status)
);

// ===== tb/sv/mlzn_checker.sv =====
// Checker for the z-score normalizer: predicts each result word and compares.
module mlzn_scoreboard (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [mlzn_pkg::COUNT_W-1:0]         s_mask_count,
    input  logic signed [mlzn_pkg::SUM_W-1:0]    s_masked_sum,
    input  logic [mlzn_pkg::SQSUM_W-1:0]         s_masked_square_sum,
    input  logic signed [15:0]                   s_centre_pixel,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [mlzn_pkg::RESULT_W-1:0] m_normalized_value,
    input  logic [1:0]                           m_status,
    output int                                   errors,
    output int                                   pending
);
    typedef struct packed {
        logic signed [mlzn_pkg::RESULT_W-1:0] value;
        mlzn_pkg::status_t                    status;
    } zscore_t;

    zscore_t score_q[$];

    // True when magnitude r does not exceed the score: (2r-1)^2 * d <= (2a)^2.
    function automatic bit fits(longint unsigned r, longint unsigned d,
                                longint unsigned a);
        logic [127:0] lhs;
        logic [127:0] rhs;
        if (r == 0) return 1'b1;
        lhs = 128'(2 * r - 1) * 128'(2 * r - 1) * 128'(d);
        rhs = 128'(2 * a) * 128'(2 * a);
        return lhs <= rhs;
    endfunction

    function automatic zscore_t predict_zscore(logic [mlzn_pkg::COUNT_W-1:0] n_raw,
                                               logic signed [mlzn_pkg::SUM_W-1:0] s_raw,
                                               logic [mlzn_pkg::SQSUM_W-1:0] q_raw,
                                               logic signed [15:0] x_raw);
        zscore_t         res;
        longint          n;
        longint          s;
        longint          q;
        longint          x;
        longint          d;
        longint          num;
        longint unsigned a;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        n = longint'(n_raw);
        s = longint'(s_raw);
        q = longint'(q_raw);
        x = longint'(x_raw);
        res.value = '0;
        if (n == 0) begin
            res.status = mlzn_pkg::ST_EMPTY;
            return res;
        end
        d = n * q - s * s;
        if (d <= 0) begin
            res.status = mlzn_pkg::ST_FLAT;
            return res;
        end
        num = n * x - s;
        a = (num < 0) ? longint'(-num) : longint'(num);
        a = a << mlzn_pkg::FRAC_BITS_DEF;
        lo = 0;
        hi = (num < 0) ? 32768 : 32767;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (fits(mid, d, a)) lo = mid;
            else hi = mid - 1;
        end
        res.value = (num < 0) ? mlzn_pkg::RESULT_W'(-lo) : mlzn_pkg::RESULT_W'(lo);
        res.status = mlzn_pkg::ST_OK;
        return res;
    endfunction

    assign pending = score_q.size();

    initial errors = 0;

    always @(posedge aclk) begin
        zscore_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                score_q = {score_q, predict_zscore(s_mask_count, s_masked_sum,
                                                   s_masked_square_sum, s_centre_pixel)};
            if (m_valid && m_ready) begin
                if (score_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    errors = errors + 1;
                end else begin
                    want = score_q.pop_front();
                    if (m_normalized_value !== want.value) begin
                        $error("normalized_value: expected %0d, actual %0d",
                               want.value, m_normalized_value);
                        errors = errors + 1;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_status);
                        errors = errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the z-score normalizer testbench: clock, reset, stimulus and verdict.
module tb;
    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [mlzn_pkg::COUNT_W-1:0]         s_mask_count;
    logic signed [mlzn_pkg::SUM_W-1:0]    s_masked_sum;
    logic [mlzn_pkg::SQSUM_W-1:0]         s_masked_square_sum;
    logic signed [15:0]                   s_centre_pixel;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [mlzn_pkg::RESULT_W-1:0] m_normalized_value;
    logic [1:0]                           m_status;
    int                                   errors;
    int                                   pending;
    int                                   send_idle_pct;
    int                                   recv_stall_pct;

    masked_local_zscore_normalize u_top (.*);

    mlzn_scoreboard u_checker (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_mask_count = '0;
        s_masked_sum = '0;
        s_masked_square_sum = '0;
        s_centre_pixel = '0;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Drives one word and holds it until it is taken, then maybe idles.
    task automatic send_word(logic [mlzn_pkg::COUNT_W-1:0] n,
                             logic signed [mlzn_pkg::SUM_W-1:0] s,
                             logic [mlzn_pkg::SQSUM_W-1:0] q, logic signed [15:0] x);
        s_valid <= 1'b1;
        s_mask_count <= n;
        s_masked_sum <= s;
        s_masked_square_sum <= q;
        s_centre_pixel <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Window statistics built from actual pixels, so the variance is consistent.
    task automatic send_window(int count, int spread);
        longint s;
        longint q;
        longint p;
        int     centre;
        s = 0;
        q = 0;
        centre = int'($urandom_range(65535)) - 32768;
        for (int i = 0; i < count; i++) begin
            p = longint'(centre) + longint'($urandom_range(2 * spread)) - spread;
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            s += p;
            q += p * p;
        end
        send_word(mlzn_pkg::COUNT_W'(count), mlzn_pkg::SUM_W'(s),
                  mlzn_pkg::SQSUM_W'(q), 16'(centre));
    endtask

    task automatic send_random();
        int kind;
        int count;
        kind = $urandom_range(99);
        count = ($urandom_range(19) == 0) ? $urandom_range(4096, 1)
                                          : $urandom_range(64, 1);
        if (kind < 65)
            send_window(count, $urandom_range(1) ? 32768 : $urandom_range(300));
        else if (kind < 72)
            send_word('0, mlzn_pkg::SUM_W'($urandom),
                      mlzn_pkg::SQSUM_W'({$urandom, $urandom}), 16'($urandom));
        else
            send_word(mlzn_pkg::COUNT_W'($urandom), mlzn_pkg::SUM_W'($urandom),
                      mlzn_pkg::SQSUM_W'({$urandom, $urandom}), 16'($urandom));
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty mask, flat and negative variance, saturation, extremes.
        send_word('0, '0, '0, '0);
        send_word('1, '1, '1, 16'sh7fff);
        send_word(13'd1, 28'sd5, 43'd25, 16'sd5);
        send_word(13'd2, 28'sd100, 43'd10, 16'sd0);
        send_word(13'd1, 28'sd0, 43'd1, 16'sh7fff);
        send_word(13'd1, 28'sd0, 43'd1, -16'sh8000);
        send_word(13'd2, -28'sd1, 43'h0fffe0001 * 2 + 43'd1, 16'sh7fff);
        send_word(13'd2, 28'sd2, 43'd4, 16'sd1);
        send_word(13'd4096, -28'sh8000000, '1, -16'sh8000);
        send_word(13'd4096, 28'sh7ffffff, 43'h40000000000, 16'sh7fff);
        send_word('1, -28'sh8000000, '1, 16'sd0);
        send_word(13'd3, 28'sd3, 43'd5, 16'sd2);
        send_word(13'd4, 28'sd0, 43'd1, 16'sd0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 38; recv_stall_pct = 38; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 270; i++) send_random();
            if (phase == 2) drain();
        end

        drain();
        recv_stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
